>>> rtl/core/scp_pkg.sv
// Shared widths for the scan point clustering core.
// No dependencies; imported by every module of the core.
package scp_pkg;

  localparam int COORD_W = 16;
  localparam int PROD_W  = 2 * COORD_W;
  localparam int SUM_W   = 27;
  localparam int CNT_W   = 12;
  localparam int ID_W    = 8;

endpackage

>>> rtl/core/scp_sqdist.sv
// Bit-serial squared-distance test: dx*dx + dy*dy <= r*r, one multiplier bit per cycle.
// Depends on scp_pkg.
module scp_sqdist
  import scp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [COORD_W-1:0] dx,
  input  logic [COORD_W-1:0] dy,
  input  logic [COORD_W-1:0] rad,
  output logic               done,
  output logic               is_near
);

  localparam int CntW = $clog2(COORD_W);

  logic [COORD_W-1:0] mx_r, my_r, mr_r, mx_nxt, my_nxt, mr_nxt;
  logic [PROD_W-1:0]  ax_r, ay_r, ar_r, ax_nxt, ay_nxt, ar_nxt;
  logic [PROD_W:0]    accd_r, accd_nxt;
  logic [PROD_W-1:0]  accr_r, accr_nxt;
  logic [CntW-1:0]    cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt, done_r, done_nxt;
  logic [PROD_W-1:0]  ppx, ppy, ppr;

  always_comb begin
    ppx = mx_r[0] ? ax_r : '0;
    ppy = my_r[0] ? ay_r : '0;
    ppr = mr_r[0] ? ar_r : '0;
    mx_nxt   = mx_r;
    my_nxt   = my_r;
    mr_nxt   = mr_r;
    ax_nxt   = ax_r;
    ay_nxt   = ay_r;
    ar_nxt   = ar_r;
    accd_nxt = accd_r;
    accr_nxt = accr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      mx_nxt   = dx;
      my_nxt   = dy;
      mr_nxt   = rad;
      ax_nxt   = PROD_W'(dx);
      ay_nxt   = PROD_W'(dy);
      ar_nxt   = PROD_W'(rad);
      accd_nxt = '0;
      accr_nxt = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      accd_nxt = accd_r + {1'b0, ppx} + {1'b0, ppy};
      accr_nxt = accr_r + ppr;
      mx_nxt   = mx_r >> 1;
      my_nxt   = my_r >> 1;
      mr_nxt   = mr_r >> 1;
      ax_nxt   = ax_r << 1;
      ay_nxt   = ay_r << 1;
      ar_nxt   = ar_r << 1;
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == CntW'(COORD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    mx_r   <= mx_nxt;
    my_r   <= my_nxt;
    mr_r   <= mr_nxt;
    ax_r   <= ax_nxt;
    ay_r   <= ay_nxt;
    ar_r   <= ar_nxt;
    accd_r <= accd_nxt;
    accr_r <= accr_nxt;
  end

  assign done    = done_r;
  assign is_near = (accd_r <= {1'b0, accr_r});

endmodule

>>> rtl/core/scp_div.sv
// Restoring divider for the centroid: one quotient bit per cycle.
// Depends on scp_pkg.
module scp_div
  import scp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [SUM_W-1:0] quotient
);

  localparam int CntW = $clog2(SUM_W);

  logic [SUM_W-1:0] q_r, q_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt, dvs_r, dvs_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt;
  logic [CNT_W:0]   rem_sh, diff;
  logic             ge;

  always_comb begin
    rem_sh   = {rem_r, q_r[SUM_W-1]};
    diff     = rem_sh - {1'b0, dvs_r};
    ge       = ~diff[CNT_W];
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      q_nxt   = {q_r[SUM_W-2:0], ge};
      rem_nxt = ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CntW'(SUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

>>> rtl/core/scan_point_cluster_centroid_core.sv
// Top level of the scan point clustering core: leader clustering with centroid output.
// Depends on scp_pkg, scp_sqdist and scp_div.
//
//   channel | handshake       | beat contents
//   --------+-----------------+----------------------------------------------------------
//   in      | in_valid/stall  | point_x, point_y, scan_end
//   out     | out_valid/stall | centroid_x, centroid_y, cluster_id, point_count, overflow,
//           |                 | final_of_scan
//   cfg     | cfg_valid/ready | radius
//
// A point that opens the first cluster is taken in S_IDLE and one that joins waits in
// S_DIST; the serial distance test runs one multiplier bit per cycle. A point that closes
// a cluster adds S_DIV, with the 27-step serial divider, and S_LOAD; the cluster emitted at
// scan end adds S_FIN, S_DIV and S_LOAD, so a beat that closes two clusters divides twice.
// Reset is synchronous and active low; it clears all cluster state and loads radius 328.
// The output register frees the input side, but a new centroid waits while out_stall holds.
module scan_point_cluster_centroid_core
  import scp_pkg::*;
#(
  parameter int MAX_CLUSTER_POINTS = 2048,
  parameter int MAX_CLUSTERS       = 256,
  parameter int COORD_BITS         = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [COORD_W-1:0] in_point_x,
  input  logic [COORD_W-1:0] in_point_y,
  input  logic               in_scan_end,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COORD_W-1:0] out_centroid_x,
  output logic [COORD_W-1:0] out_centroid_y,
  output logic [ID_W-1:0]    out_cluster_id,
  output logic [CNT_W-1:0]   out_point_count,
  output logic               out_overflow,
  output logic               out_final_of_scan,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COORD_W-1:0] cfg_radius
);

  localparam int CoordMaskI = (COORD_BITS >= COORD_W) ? 65535 : ((1 << COORD_BITS) - 1);
  localparam int CountTopI  = (MAX_CLUSTER_POINTS > 4095) ? 4095 : MAX_CLUSTER_POINTS;
  localparam int IdTopI     = (MAX_CLUSTERS - 1 > 255) ? 255 : (MAX_CLUSTERS - 1);
  localparam logic [COORD_W-1:0] CoordMask = CoordMaskI[COORD_W-1:0];
  localparam logic [CNT_W-1:0]   CountTop  = CountTopI[CNT_W-1:0];
  localparam logic [ID_W-1:0]    IdTop     = IdTopI[ID_W-1:0];
  localparam logic [COORD_W-1:0] RadiusRst = 16'd328;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIST = 3'd1;
  localparam logic [2:0] S_FIN  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_LOAD = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [COORD_W-1:0] radius_r, radius_nxt;
  logic [COORD_W-1:0] anchor_x_r, anchor_x_nxt, anchor_y_r, anchor_y_nxt;
  logic [SUM_W-1:0]   sum_x_r, sum_x_nxt, sum_y_r, sum_y_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [ID_W-1:0]    cur_id_r, cur_id_nxt;
  logic               open_r, open_nxt, sat_r, sat_nxt;
  logic [COORD_W-1:0] px_r, px_nxt, py_r, py_nxt;
  logic               last_r, last_nxt, pend_r, pend_nxt;
  logic [ID_W-1:0]    snap_id_r, snap_id_nxt;
  logic [CNT_W-1:0]   snap_cnt_r, snap_cnt_nxt;
  logic               snap_sat_r, snap_sat_nxt, snap_fin_r, snap_fin_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [COORD_W-1:0] out_cx_r, out_cx_nxt, out_cy_r, out_cy_nxt;
  logic [ID_W-1:0]    out_id_r, out_id_nxt;
  logic [CNT_W-1:0]   out_cnt_r, out_cnt_nxt;
  logic               out_ovf_r, out_ovf_nxt, out_fin_r, out_fin_nxt;

  logic [COORD_W-1:0] pt_x, pt_y, dx_in, dy_in;
  logic               in_accept, dist_start, dist_done, is_near;
  logic               div_start, divx_done, divy_done;
  logic [SUM_W-1:0]   quot_x, quot_y;
  logic [SUM_W:0]     add_x, add_y;

  assign pt_x      = in_point_x & CoordMask;
  assign pt_y      = in_point_y & CoordMask;
  assign dx_in     = (pt_x >= anchor_x_r) ? (pt_x - anchor_x_r) : (anchor_x_r - pt_x);
  assign dy_in     = (pt_y >= anchor_y_r) ? (pt_y - anchor_y_r) : (anchor_y_r - pt_y);
  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid & ~in_stall;
  assign cfg_ready = (state_r == S_IDLE);
  assign dist_start = in_accept & open_r;
  assign add_x     = {1'b0, sum_x_r} + (SUM_W + 1)'(px_r);
  assign add_y     = {1'b0, sum_y_r} + (SUM_W + 1)'(py_r);

  scp_sqdist u_sqdist (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (dist_start),
    .dx      (dx_in),
    .dy      (dy_in),
    .rad     (radius_r),
    .done    (dist_done),
    .is_near (is_near)
  );

  scp_div u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_x_r),
    .divisor  (count_r),
    .done     (divx_done),
    .quotient (quot_x)
  );

  scp_div u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_y_r),
    .divisor  (count_r),
    .done     (divy_done),
    .quotient (quot_y)
  );

  always_comb begin
    state_nxt    = state_r;
    radius_nxt   = radius_r;
    anchor_x_nxt = anchor_x_r;
    anchor_y_nxt = anchor_y_r;
    sum_x_nxt    = sum_x_r;
    sum_y_nxt    = sum_y_r;
    count_nxt    = count_r;
    cur_id_nxt   = cur_id_r;
    open_nxt     = open_r;
    sat_nxt      = sat_r;
    px_nxt       = px_r;
    py_nxt       = py_r;
    last_nxt     = last_r;
    pend_nxt     = pend_r;
    snap_id_nxt  = snap_id_r;
    snap_cnt_nxt = snap_cnt_r;
    snap_sat_nxt = snap_sat_r;
    snap_fin_nxt = snap_fin_r;
    out_cx_nxt   = out_cx_r;
    out_cy_nxt   = out_cy_r;
    out_id_nxt   = out_id_r;
    out_cnt_nxt  = out_cnt_r;
    out_ovf_nxt  = out_ovf_r;
    out_fin_nxt  = out_fin_r;
    out_valid_nxt = out_valid_r & out_stall;
    div_start    = 1'b0;

    if (cfg_valid && cfg_ready) begin
      radius_nxt = cfg_radius;
    end

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          px_nxt   = pt_x;
          py_nxt   = pt_y;
          last_nxt = in_scan_end;
          if (open_r) begin
            state_nxt = S_DIST;
          end else begin
            anchor_x_nxt = pt_x;
            anchor_y_nxt = pt_y;
            sum_x_nxt    = SUM_W'(pt_x);
            sum_y_nxt    = SUM_W'(pt_y);
            count_nxt    = CNT_W'(1);
            sat_nxt      = 1'b0;
            open_nxt     = 1'b1;
            if (in_scan_end) begin
              state_nxt = S_FIN;
            end
          end
        end
      end
      S_DIST: begin
        if (dist_done) begin
          if (is_near) begin
            if (count_r >= CountTop || add_x[SUM_W] || add_y[SUM_W]) begin
              sat_nxt = 1'b1;
            end else begin
              sum_x_nxt = add_x[SUM_W-1:0];
              sum_y_nxt = add_y[SUM_W-1:0];
              count_nxt = count_r + 1'b1;
            end
            state_nxt = last_r ? S_FIN : S_IDLE;
          end else begin
            div_start    = 1'b1;
            snap_id_nxt  = cur_id_r;
            snap_cnt_nxt = count_r;
            snap_sat_nxt = sat_r;
            snap_fin_nxt = 1'b0;
            if (cur_id_r < IdTop) begin
              cur_id_nxt = cur_id_r + 1'b1;
            end
            anchor_x_nxt = px_r;
            anchor_y_nxt = py_r;
            sum_x_nxt    = SUM_W'(px_r);
            sum_y_nxt    = SUM_W'(py_r);
            count_nxt    = CNT_W'(1);
            sat_nxt      = 1'b0;
            pend_nxt     = last_r;
            state_nxt    = S_DIV;
          end
        end
      end
      S_FIN: begin
        div_start    = 1'b1;
        snap_id_nxt  = cur_id_r;
        snap_cnt_nxt = count_r;
        snap_sat_nxt = sat_r;
        snap_fin_nxt = 1'b1;
        anchor_x_nxt = '0;
        anchor_y_nxt = '0;
        sum_x_nxt    = '0;
        sum_y_nxt    = '0;
        count_nxt    = '0;
        cur_id_nxt   = '0;
        open_nxt     = 1'b0;
        sat_nxt      = 1'b0;
        pend_nxt     = 1'b0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        if (divx_done && divy_done) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_cx_nxt  = (quot_x > SUM_W'(CoordMask)) ? CoordMask : quot_x[COORD_W-1:0];
          out_cy_nxt  = (quot_y > SUM_W'(CoordMask)) ? CoordMask : quot_y[COORD_W-1:0];
          out_id_nxt  = snap_id_r;
          out_cnt_nxt = snap_cnt_r;
          out_ovf_nxt = snap_sat_r;
          out_fin_nxt = snap_fin_r;
          state_nxt   = pend_r ? S_FIN : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      radius_r    <= RadiusRst;
      anchor_x_r  <= '0;
      anchor_y_r  <= '0;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      count_r     <= '0;
      cur_id_r    <= '0;
      open_r      <= 1'b0;
      sat_r       <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      radius_r    <= radius_nxt;
      anchor_x_r  <= anchor_x_nxt;
      anchor_y_r  <= anchor_y_nxt;
      sum_x_r     <= sum_x_nxt;
      sum_y_r     <= sum_y_nxt;
      count_r     <= count_nxt;
      cur_id_r    <= cur_id_nxt;
      open_r      <= open_nxt;
      sat_r       <= sat_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    last_r     <= last_nxt;
    snap_id_r  <= snap_id_nxt;
    snap_cnt_r <= snap_cnt_nxt;
    snap_sat_r <= snap_sat_nxt;
    snap_fin_r <= snap_fin_nxt;
    out_cx_r   <= out_cx_nxt;
    out_cy_r   <= out_cy_nxt;
    out_id_r   <= out_id_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_ovf_r  <= out_ovf_nxt;
    out_fin_r  <= out_fin_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_centroid_x    = out_cx_r;
  assign out_centroid_y    = out_cy_r;
  assign out_cluster_id    = out_id_r;
  assign out_point_count   = out_cnt_r;
  assign out_overflow      = out_ovf_r;
  assign out_final_of_scan = out_fin_r;

endmodule
